// ===== rtl/cic_pkg.sv =====
`default_nettype none
package cic_pkg;

	localparam int DATA_W  = 32;
	localparam int TOL_W   = 31;
	localparam int COUNT_W = 20;
	localparam int INDEX_W = 17;
	// quotient bits produced by the divider; the index never exceeds one in Q1.16
	localparam int QUOT_BITS = 17;
	localparam int FRAC_W    = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
	localparam logic [INDEX_W-1:0] INDEX_HALF = 17'd32768;
	localparam logic [INDEX_W-1:0] INDEX_ONE  = 17'd65536;

	// register indexes (word address bit above the byte offset)
	localparam logic REG_TIE_TOL = 1'b0;

	typedef struct packed {
		logic              seen;
		logic [DATA_W-1:0] etime;
		logic [DATA_W-1:0] risk;
	} rec_t;

endpackage
`default_nettype wire

// ===== rtl/concordance_index_counter.sv =====
// channel  | direction | handshake         | payload
// ---------+-----------+-------------------+---------------------------------------------
// input    | in        | in_valid/in_stall | risk, event_time, event_seen, last_record
// output   | out       | out_valid/out_stall | index_value, concordant_pairs, tied_pairs,
//          |           |                   | comparable_pairs, overflow_seen
// config   | in        | APB               | tie_tolerance at byte address 0
//
// Records load at one per cycle, while in_stall is low, into a single-port-read record RAM.
// After the last record the pair walk reads each of the N stored records once and, for
// each of the E events, all N records again, bound by the one RAM read port; then the
// divider runs and the result is loaded, input stalling until then. No reset sweep: the
// RAM needs no clearing. A waiting result does not block loading the next set.
`default_nettype none
module concordance_index_counter #(
	parameter int MAX_RECORDS = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic signed [31:0] risk,
	input  wire logic [31:0] event_time,
	input  wire logic        event_seen,
	input  wire logic        last_record,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [16:0]      index_value,
	output logic [19:0]      concordant_pairs,
	output logic [19:0]      tied_pairs,
	output logic [19:0]      comparable_pairs,
	output logic             overflow_seen
);

	localparam int AW = $clog2(MAX_RECORDS);
	localparam int CW = $clog2(MAX_RECORDS + 1);
	localparam int PW = 2 * CW;
	localparam int XW = PW + cic_pkg::COUNT_W;
	localparam int RW = $bits(cic_pkg::rec_t);

	typedef enum logic [6:0] {
		S_LOAD   = 7'b0000001,
		S_RD_I   = 7'b0000010,
		S_WAIT_I = 7'b0000100,
		S_WALK   = 7'b0001000,
		S_DRAIN  = 7'b0010000,
		S_DIV    = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t                      state_q;
	logic [cic_pkg::TOL_W-1:0]   tol_q;
	logic [CW-1:0]               cnt_q;
	logic                        drop_q;
	logic [CW-1:0]               i_q;
	logic [CW-1:0]               j_q;
	logic [31:0]                 ri_q;
	logic [31:0]                 ti_q;
	logic                        v_s1;
	logic                        v_s2;
	logic                        cmp_s2;
	logic signed [32:0]          diff_s2;
	logic [PW-1:0]               conc_q;
	logic [PW-1:0]               tied_q;
	logic [PW-1:0]               comp_q;
	logic                        out_valid_q;

	logic                        in_acc;
	logic                        full;
	logic                        ram_we;
	logic [AW-1:0]               ram_raddr;
	cic_pkg::rec_t               wrec;
	cic_pkg::rec_t               rrec;
	logic [RW-1:0]               rdata_raw;
	logic signed [32:0]          tol_pos;
	logic signed [32:0]          tol_neg;
	logic signed [32:0]          diff_s1;
	logic                        div_start;
	logic                        div_done;
	logic [cic_pkg::INDEX_W-1:0] div_quot;
	logic                        out_free;

	function automatic logic [cic_pkg::COUNT_W-1:0] clip(input logic [PW-1:0] c);
		logic [XW-1:0] x;
		x = XW'(c);
		clip = (x > XW'(cic_pkg::COUNT_MAX)) ? cic_pkg::COUNT_MAX : x[cic_pkg::COUNT_W-1:0];
	endfunction

	// configuration
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == cic_pkg::REG_TIE_TOL) begin
			tol_q <= pwdata[cic_pkg::TOL_W-1:0];
		end
	end
	assign prdata = (paddr[2] == cic_pkg::REG_TIE_TOL) ? {1'b0, tol_q} : 32'd0;

	assign in_stall = (state_q != S_LOAD);
	assign in_acc   = in_valid && !in_stall;
	assign full     = (cnt_q == CW'(MAX_RECORDS));
	assign ram_we   = in_acc && !full;
	assign wrec     = '{seen: event_seen, etime: event_time, risk: risk};
	assign ram_raddr = (state_q == S_WALK) ? j_q[AW-1:0] : i_q[AW-1:0];

	cic_ram #(
		.WIDTH(RW),
		.DEPTH(MAX_RECORDS)
	) u_rec_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[AW-1:0]),
		.wdata(wrec),
		.raddr(ram_raddr),
		.rdata(rdata_raw)
	);
	assign rrec = cic_pkg::rec_t'(rdata_raw);

	assign tol_pos = $signed({2'b00, tol_q});
	assign tol_neg = -tol_pos;
	assign diff_s1 = $signed({ri_q[31], ri_q}) - $signed({rrec.risk[31], rrec.risk});

	assign out_free  = !out_valid_q || !out_stall;
	assign div_start = (state_q == S_RD_I) && (i_q == cnt_q);

	cic_div #(
		.PW(PW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.conc  (conc_q),
		.tied  (tied_q),
		.comp  (comp_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			cnt_q       <= '0;
			drop_q      <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			cmp_s2      <= 1'b0;
			conc_q      <= '0;
			tied_q      <= '0;
			comp_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1   <= (state_q == S_WALK);
			v_s2   <= v_s1;
			cmp_s2 <= v_s1 && (rrec.etime > ti_q);

			if (cmp_s2) begin
				comp_q <= comp_q + PW'(1);
				if (diff_s2 > tol_pos) begin
					conc_q <= conc_q + PW'(1);
				end else if (diff_s2 >= tol_neg) begin
					tied_q <= tied_q + PW'(1);
				end
			end

			// drop the sent result unless a new one replaces it this cycle
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (full) begin
							drop_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
						if (last_record) begin
							i_q     <= '0;
							conc_q  <= '0;
							tied_q  <= '0;
							comp_q  <= '0;
							state_q <= S_RD_I;
						end
					end
				end
				S_RD_I: begin
					state_q <= (i_q == cnt_q) ? S_DIV : S_WAIT_I;
				end
				S_WAIT_I: begin
					if (rrec.seen) begin
						j_q     <= '0;
						state_q <= S_WALK;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_RD_I;
					end
				end
				S_WALK: begin
					j_q <= j_q + CW'(1);
					if ((j_q + CW'(1)) == cnt_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// hold record i until the last pair has been counted
					if (!v_s1 && !v_s2) begin
						i_q     <= i_q + CW'(1);
						state_q <= S_RD_I;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						cnt_q       <= '0;
						drop_q      <= 1'b0;
						state_q     <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		diff_s2 <= diff_s1;
		if (state_q == S_WAIT_I) begin
			ri_q <= rrec.risk;
			ti_q <= rrec.etime;
		end
		if (state_q == S_DONE && out_free) begin
			index_value      <= div_quot;
			concordant_pairs <= clip(conc_q);
			tied_pairs       <= clip(tied_q);
			comparable_pairs <= clip(comp_q);
			overflow_seen    <= drop_q;
		end
	end

	assign out_valid = out_valid_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_RECORDS))
		else $error("record count beyond capacity");

	a_walk_addr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> j_q < cnt_q && i_q < cnt_q)
		else $error("walk reads beyond stored records");

	a_div_settled: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> !v_s1 && !v_s2 && !cmp_s2)
		else $error("division started with pairs still in flight");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the division phase");

endmodule
`default_nettype wire

// ===== rtl/cic_ram.sv =====
`default_nettype none
module cic_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/cic_div.sv =====
`default_nettype none
// Index = floor(((2C + T) * 2^16 + K) / (2K)), one quotient bit per cycle.
module cic_div #(
	parameter int PW = 22
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [PW-1:0]                    conc,
	input  wire logic [PW-1:0]                    tied,
	input  wire logic [PW-1:0]                    comp,
	output logic                                  done,
	output logic      [cic_pkg::INDEX_W-1:0]      quot
);

	localparam int NW = PW + 1 + cic_pkg::FRAC_W;
	localparam int SW = $clog2(cic_pkg::QUOT_BITS + 1);

	logic [NW-1:0]                   num;
	logic [PW:0]                     rem_q;
	logic [PW:0]                     den_q;
	logic [cic_pkg::QUOT_BITS-1:0]   shq_q;
	logic [SW-1:0]                   step_q;
	logic                            busy_q;
	logic                            done_q;
	logic [cic_pkg::INDEX_W-1:0]     quot_q;
	logic [PW+1:0]                   trial;
	logic                            qbit;
	logic [PW+1:0]                   diff;

	assign num   = {({conc, 1'b0} + {1'b0, tied}), {cic_pkg::FRAC_W{1'b0}}} + NW'(comp);
	assign trial = {rem_q, shq_q[cic_pkg::QUOT_BITS-1]};
	assign qbit  = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= (start && comp == '0) || (!start && busy_q && step_q == SW'(1));
			if (start) begin
				if (comp != '0) begin
					busy_q <= 1'b1;
					step_q <= SW'(cic_pkg::QUOT_BITS);
				end
			end else if (busy_q) begin
				step_q <= step_q - SW'(1);
				if (step_q == SW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// quotient stays below 2^17, so the upper part is already below the divisor
			rem_q  <= {1'b0, num[NW-1:cic_pkg::QUOT_BITS]};
			shq_q  <= num[cic_pkg::QUOT_BITS-1:0];
			den_q  <= {comp, 1'b0};
			quot_q <= cic_pkg::INDEX_HALF;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[PW:0] : trial[PW:0];
			shq_q <= {shq_q[cic_pkg::QUOT_BITS-2:0], qbit};
			if (step_q == SW'(1)) begin
				quot_q <= ({shq_q[cic_pkg::QUOT_BITS-2:0], qbit} > cic_pkg::INDEX_ONE) ?
					cic_pkg::INDEX_ONE : {shq_q[cic_pkg::QUOT_BITS-2:0], qbit};
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire
